// ----- rtl/core/ir_mark_space_duration_capture_assert.svh -----
// assertion macros for the infrared mark/space capture block
`ifndef IR_MARK_SPACE_DURATION_CAPTURE_ASSERT_SVH
`define IR_MARK_SPACE_DURATION_CAPTURE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IRMSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irmsd same-cycle check failed");

// next-cycle implication, checked outside reset
`define IRMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irmsd next-cycle check failed");

`endif

// ----- rtl/core/irmsd_pkg.sv -----
// shared types and constants of the infrared mark/space capture block
package irmsd_pkg;

    localparam int TICK_W = 24;
    localparam int DUR_W  = 16;
    localparam int SLOT_W = 8;
    localparam int KIND_W = 3;
    localparam int CFG_W  = 24;

    localparam logic [KIND_W-1:0] KIND_MARK       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SPACE      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_END_GAP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NO_SIGNAL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BUF_FULL   = 3'd4;

    localparam logic CFG_BEGIN_TIMEOUT = 1'b0;
    localparam logic CFG_END_TIMEOUT   = 1'b1;

    localparam logic [TICK_W-1:0] BEGIN_TIMEOUT_RST = 24'd100000;
    localparam logic [DUR_W-1:0]  END_TIMEOUT_RST   = 16'd700;

    typedef struct packed {
        logic cmd;
        logic ir_mark;
    } in_item_t;

    typedef struct packed {
        logic [DUR_W-1:0]  duration;
        logic [SLOT_W-1:0] slot;
        logic [KIND_W-1:0] kind;
    } res_t;

    typedef struct packed {
        logic [TICK_W-1:0] begin_timeout;
        logic [DUR_W-1:0]  end_timeout;
    } cfg_t;

endpackage

// ----- rtl/core/irmsd_if.sv -----
// item channel interfaces of the infrared mark/space capture block
interface irmsd_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic ir_mark;

    modport source (output valid, output cmd, output ir_mark, input ready);
    modport sink   (input valid, input cmd, input ir_mark, output ready);
endinterface

interface irmsd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] duration;
    logic [7:0]  slot;
    logic [2:0]  kind;

    modport source (output valid, output duration, output slot, output kind, input ready);
    modport sink   (input valid, input duration, input slot, input kind, output ready);
endinterface

// ----- rtl/core/ir_mark_space_duration_capture.sv -----
// top level of the infrared mark/space duration capture block
// an accepted item goes to the input register stage, its result to the result register
// throughput: one item per cycle unless a result is blocked, set by the state loop
// a stalled result register holds the input stage, which then holds the channel
// reset: asynchronous active low, phase idle, counts zero, timeouts at defaults
`include "ir_mark_space_duration_capture_assert.svh"

module ir_mark_space_duration_capture #(
    parameter int CAPTURE_LENGTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_idx,
    input  logic [23:0]        cfg_wdata,
    irmsd_in_if.sink           in_ch,
    irmsd_out_if.source        out_ch
);
    import irmsd_pkg::*;

    // timeout registers
    cfg_t     cfg;

    // input register stage
    in_item_t in_item;
    in_item_t stage_item;
    logic     stage_vld;

    // step logic and result register
    logic     advance;
    logic     step_res_vld;
    res_t     step_res;
    res_t     out_res;
    logic     out_free;

    // helpers for the checks below
    logic     out_blocked;
    logic     full_shown;
    logic     full_fields_zero;

    assign in_item.cmd     = in_ch.cmd;
    assign in_item.ir_mark = in_ch.ir_mark;

    // the held item is processed once the result register has room,
    // whether or not it turns out to produce a result
    assign advance = stage_vld && out_free;

    irmsd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    irmsd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_item    (in_item),
        .advance    (advance),
        .in_ready   (in_ch.ready),
        .stage_vld  (stage_vld),
        .stage_item (stage_item)
    );

    irmsd_step #(
        .CAPTURE_LENGTH (CAPTURE_LENGTH)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (advance),
        .item    (stage_item),
        .res_vld (step_res_vld),
        .res     (step_res)
    );

    // only items that produce a result land in the result register
    irmsd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step_res_vld),
        .res       (step_res),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_res   (out_res),
        .out_free  (out_free)
    );

    assign out_ch.duration = out_res.duration;
    assign out_ch.slot     = out_res.slot;
    assign out_ch.kind     = out_res.kind;

    assign out_blocked      = out_ch.valid && !out_ch.ready;
    assign full_shown       = out_ch.valid && (out_ch.kind == KIND_BUF_FULL);
    assign full_fields_zero = (out_ch.duration == 16'd0) && (out_ch.slot == 8'd0);

    // back-pressure reaches the input only through a blocked result
    `IRMSD_ASSERT_NOW(a_ready_only_blocked, clk, rst_n, !in_ch.ready, out_blocked)

    // a rearm item never yields a result
    `IRMSD_ASSERT_NOW(a_rearm_silent, clk, rst_n, advance && stage_item.cmd, !step_res_vld)

    // a buffer-full stop carries zero duration and slot
    `IRMSD_ASSERT_NOW(a_full_zero, clk, rst_n, full_shown, full_fields_zero)

    // a produced result is visible on the output the next cycle
    `IRMSD_ASSERT_NEXT(a_result_shown, clk, rst_n, advance && step_res_vld, out_ch.valid)
endmodule

// ----- rtl/core/irmsd_cfg_regs.sv -----
// timeout configuration registers
module irmsd_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_idx,
    input  logic [23:0]            cfg_wdata,
    output irmsd_pkg::cfg_t        cfg
);
    import irmsd_pkg::*;

    logic [TICK_W-1:0] begin_to_reg;
    logic [DUR_W-1:0]  end_to_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_to_reg <= BEGIN_TIMEOUT_RST;
            end_to_reg   <= END_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_BEGIN_TIMEOUT: begin_to_reg <= cfg_wdata[TICK_W-1:0];
                CFG_END_TIMEOUT:   end_to_reg   <= cfg_wdata[DUR_W-1:0];
                default:           end_to_reg   <= end_to_reg;
            endcase
        end
    end

    assign cfg.begin_timeout = begin_to_reg;
    assign cfg.end_timeout   = end_to_reg;
endmodule

// ----- rtl/core/irmsd_in_stage.sv -----
// input register stage
module irmsd_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  irmsd_pkg::in_item_t   in_item,
    input  logic                  advance,
    output logic                  in_ready,
    output logic                  stage_vld,
    output irmsd_pkg::in_item_t   stage_item
);
    import irmsd_pkg::*;

    logic     vld_reg;
    in_item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign in_ready = !vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_vld  = vld_reg;
    assign stage_item = item_reg;
endmodule

// ----- rtl/core/irmsd_step.sv -----
// capture state and per-tick update logic
module irmsd_step #(
    parameter int CAPTURE_LENGTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  irmsd_pkg::cfg_t       cfg,
    input  logic                  fire,
    input  irmsd_pkg::in_item_t   item,
    output logic                  res_vld,
    output irmsd_pkg::res_t       res
);
    import irmsd_pkg::*;

    localparam int ENT_W = $clog2(CAPTURE_LENGTH + 1);
    localparam logic [ENT_W-1:0]  ENT_FULL = ENT_W'(CAPTURE_LENGTH);
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MARK  = 2'd1;
    localparam logic [1:0] PH_SPACE = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [ENT_W-1:0]  entry_reg, entry_next;

    logic [TICK_W-1:0] tick_inc;
    logic [DUR_W-1:0]  dur_sat;
    logic [8:0]        entry_wide;
    logic              full;

    assign tick_inc   = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 24'd1;
    assign dur_sat    = (|tick_inc[TICK_W-1:DUR_W]) ? {DUR_W{1'b1}} : tick_inc[DUR_W-1:0];
    assign entry_wide = 9'(entry_reg);
    assign full       = (entry_reg >= ENT_FULL);

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        entry_next   = entry_reg;
        res_vld      = 1'b0;
        res.duration = dur_sat;
        res.slot     = entry_wide[SLOT_W-1:0];
        res.kind     = KIND_MARK;

        if (item.cmd)
        begin
            // rearm keeps the tick count
            phase_next = PH_IDLE;
            entry_next = '0;
        end
        else
        begin
            tick_next = tick_inc;
            if (full)
            begin
                if (phase_reg != PH_STOP)
                begin
                    phase_next   = PH_STOP;
                    res_vld      = 1'b1;
                    res.duration = '0;
                    res.slot     = '0;
                    res.kind     = KIND_BUF_FULL;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (item.ir_mark)
                        begin
                            entry_next = '0;
                            tick_next  = '0;
                            phase_next = PH_MARK;
                        end
                        else if (tick_inc >= cfg.begin_timeout)
                        begin
                            res_vld    = 1'b1;
                            res.kind   = KIND_NO_SIGNAL;
                            tick_next  = '0;
                            phase_next = PH_STOP;
                        end
                    end
                    PH_MARK:
                    begin
                        if (!item.ir_mark)
                        begin
                            res_vld    = 1'b1;
                            res.kind   = KIND_MARK;
                            entry_next = entry_reg + 1'b1;
                            tick_next  = '0;
                            phase_next = PH_SPACE;
                        end
                    end
                    PH_SPACE:
                    begin
                        if (item.ir_mark)
                        begin
                            res_vld    = 1'b1;
                            res.kind   = KIND_SPACE;
                            entry_next = entry_reg + 1'b1;
                            tick_next  = '0;
                            phase_next = PH_MARK;
                        end
                        else if (tick_inc > TICK_W'(cfg.end_timeout))
                        begin
                            // ending gap keeps the tick count
                            res_vld    = 1'b1;
                            res.kind   = KIND_END_GAP;
                            entry_next = entry_reg + 1'b1;
                            phase_next = PH_STOP;
                        end
                    end
                    PH_STOP:
                    begin
                        phase_next = PH_STOP;
                    end
                    default:
                    begin
                        phase_next = PH_STOP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            entry_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            entry_reg <= entry_next;
        end
    end
endmodule

// ----- rtl/core/irmsd_out_stage.sv -----
// result register stage
module irmsd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  irmsd_pkg::res_t  res,
    input  logic             out_ready,
    output logic             out_valid,
    output irmsd_pkg::res_t  out_res,
    output logic             out_free
);
    import irmsd_pkg::*;

    logic vld_reg;
    res_t res_reg;

    assign out_free = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;
endmodule
